// ----- hw/rtl/rtss_pkg.sv -----
// ============================================================================
// rtss_pkg
// shared widths, defaults and codes of the lstm state smoother
// ============================================================================
package rtss_pkg;

    localparam int DATA_W          = 32;   // signed q values
    localparam int VAR_W           = 31;   // unsigned input variances
    localparam int IDX_W           = 6;    // state index
    localparam int CNT_W           = 7;    // state count register
    localparam int GAIN_W          = 31;   // gain magnitude, one bit per divider step
    localparam int MAX_STATES_DEF  = 64;
    localparam int FRAC_BITS_DEF   = 24;

    localparam logic [CNT_W-1:0] STATE_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_VAR = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

endpackage

// ----- hw/rtl/lstm_state_rts_smoother_top.sv -----
// ============================================================================
// lstm_state_rts_smoother_top
// backward rauch-tung-striebel smoothing of lstm cell and hidden states
// ============================================================================
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata posteriors, priors, covariances
//                                     s_tuser final step flag
// m_*       out  m_tvalid / m_tready  m_tdata smoothed means and variances
//                                     m_tuser status
// cfg_*     in   cfg_valid/cfg_ready  cfg_data state count
//
// one transaction per cycle is taken while no index hazard or output stall
// holds s_tready low; the path runs through the 32 stage gain divider plus the
// multiply and round stages behind it
// a transaction whose state index matches an item still in the pipeline
// waits until that item leaves it, since the per state store is read at
// entry and written at exit
// stores need no clearing pass after reset; rst_n clears control only
// output register plus skid entry: one more result is taken while m_tready
// is low, then the pipeline holds without losing or repeating anything
//
module lstm_state_rts_smoother_top #(
    parameter int MAX_STATES = rtss_pkg::MAX_STATES_DEF,
    parameter int FRAC_BITS  = rtss_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // state_index[5:0], mu_cell_post[37:6], var_cell_post[68:38],
    // mu_hidden_post[100:69], var_hidden_post[131:101], mu_cell_prior[163:132],
    // var_cell_prior[194:164], cov_cell[226:195], cov_hidden_cell[258:227]
    input  logic [263:0] s_tdata,
    // is_final_step[0]
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_state[5:0], mu_cell_smooth[37:6], var_cell_smooth[69:38],
    // mu_hidden_smooth[101:70], var_hidden_smooth[133:102]
    output logic [135:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    // configuration: state count
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [rtss_pkg::CNT_W-1:0] cfg_data
);

    localparam int DW      = rtss_pkg::DATA_W;
    localparam int VW      = rtss_pkg::VAR_W;
    localparam int IW      = rtss_pkg::IDX_W;
    localparam int GW      = rtss_pkg::GAIN_W;
    localparam int AW      = MAX_STATES > 1 ? $clog2(MAX_STATES) : 1;
    localparam int DVW     = DW + FRAC_BITS;
    localparam int TW      = 64 - FRAC_BITS;    // rounded product magnitude
    localparam int SW      = TW + 2;            // sum before saturation
    localparam int DIV_LAT = GW + 1;
    // pipeline stage numbers
    localparam int S_DIV_IN = 1;
    localparam int S_GAIN   = S_DIV_IN + 1 + DIV_LAT;
    localparam int S_PROD   = S_GAIN + 1;
    localparam int S_RND    = S_PROD + 1;
    localparam int S_VPROD  = S_RND + 1;
    localparam int S_VRND   = S_VPROD + 1;
    localparam int NS       = S_VRND + 1;

    // fields that travel with each item
    typedef struct packed {
        logic [IW-1:0] idx;
        logic          fin;
        logic          oor;
        logic          zero;
        logic          cc_neg;
        logic          ch_neg;
        logic          dm_neg;
        logic [DW:0]   dm_mag;
        logic          dv_neg;
        logic [DW:0]   dv_mag;
        logic [DW-1:0] mcp;
        logic [VW-1:0] vcp;
        logic [DW-1:0] mhp;
        logic [VW-1:0] vhp;
    } side_t;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [DW-1:0] mcs;
        logic [DW-1:0] vcs;
        logic [DW-1:0] mhs;
        logic [DW-1:0] vhs;
        logic [1:0]    status;
    } res_t;

    function automatic logic [TW-1:0] rnd_q(input logic [63:0] p);
        logic [63:0] t;
        t = p + (64'd1 << (FRAC_BITS - 1));
        return t[63:FRAC_BITS];
    endfunction

    // post + or - term, saturated to the signed 32 bit range
    function automatic logic [DW-1:0] add_sat(input logic signed [DW-1:0] post,
                                              input logic neg,
                                              input logic [TW-1:0] mag);
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] m;
        logic signed [SW-1:0] s;
        a = SW'(post);
        m = $signed({2'b00, mag});
        s = neg ? a - m : a + m;
        if (s[SW-1:DW-1] != {(SW-DW+1){s[SW-1]}})
        begin
            return s[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        return s[DW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [rtss_pkg::CNT_W-1:0] state_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= rtss_pkg::STATE_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            state_count_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // input unpack, hazard check, accept
    // ------------------------------------------------------------------
    logic [IW-1:0]  in_idx;
    logic [DW-1:0]  in_mpr;
    logic [VW-1:0]  in_vpr;
    logic [DW-1:0]  in_cc;
    logic [DW-1:0]  in_chc;
    logic           in_oor;
    logic           hazard;
    logic           adv;
    logic           acc;
    logic [AW-1:0]  in_addr;
    side_t          sd_in;

    logic [NS-1:0]  v_reg;
    side_t          sd_reg [NS];
    side_t          sd1_next;

    assign in_idx = s_tdata[5:0];
    assign in_mpr = s_tdata[163:132];
    assign in_vpr = s_tdata[194:164];
    assign in_cc  = s_tdata[226:195];
    assign in_chc = s_tdata[258:227];
    assign in_oor = (rtss_pkg::CNT_W'(in_idx) >= state_count_reg) ||
                    (32'(in_idx) >= 32'(MAX_STATES));
    assign in_addr = AW'(in_idx);

    // an in range item in flight has not written its smoothed values yet
    always_comb
    begin
        hazard = 1'b0;
        for (int s = 0; s < NS; s++)
        begin
            if (v_reg[s] && !sd_reg[s].oor && (sd_reg[s].idx == in_idx))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign s_tready = adv && !hazard;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        sd_in        = '0;
        sd_in.idx    = in_idx;
        sd_in.fin    = s_tuser[0];
        sd_in.oor    = in_oor;
        sd_in.mcp    = s_tdata[37:6];
        sd_in.vcp    = s_tdata[68:38];
        sd_in.mhp    = s_tdata[100:69];
        sd_in.vhp    = s_tdata[131:101];
    end

    // ------------------------------------------------------------------
    // per state stores: smoothed cell values written at exit,
    // priors and covariances written at entry (read first)
    // ------------------------------------------------------------------
    logic [2*DW-1:0] ra_rdata;
    logic [4*DW-1:0] rb_rdata;
    logic            ra_we;
    logic [AW-1:0]   ra_waddr;
    logic [2*DW-1:0] ra_wdata;
    res_t            res;

    rtss_ram #(
        .WIDTH (2*DW),
        .DEPTH (MAX_STATES)
    ) u_ram_smooth (
        .clk   (clk),
        .we    (ra_we),
        .waddr (ra_waddr),
        .wdata (ra_wdata),
        .re    (acc),
        .raddr (in_addr),
        .rdata (ra_rdata)
    );

    rtss_ram #(
        .WIDTH (4*DW),
        .DEPTH (MAX_STATES)
    ) u_ram_prior (
        .clk   (clk),
        .we    (acc && !in_oor),
        .waddr (in_addr),
        .wdata ({in_chc, in_cc, {1'b0, in_vpr}, in_mpr}),
        .re    (acc),
        .raddr (in_addr),
        .rdata (rb_rdata)
    );

    // ------------------------------------------------------------------
    // stage 1: differences, dividends
    // ------------------------------------------------------------------
    logic signed [DW-1:0] l_mcs;
    logic signed [DW-1:0] l_vcs;
    logic signed [DW-1:0] l_mpr;
    logic signed [DW-1:0] l_vpr;
    logic        [DW-1:0] l_cc;
    logic        [DW-1:0] l_chc;
    logic signed [DW:0]   dm;
    logic signed [DW:0]   dv;
    logic        [DW-1:0] cc_mag;
    logic        [DW-1:0] ch_mag;

    logic [DVW-1:0] dvd_c_next;
    logic [DVW-1:0] dvd_h_next;
    logic [DVW-1:0] dvd_c_reg;
    logic [DVW-1:0] dvd_h_reg;
    logic [GW-1:0]  dsr_reg;

    assign l_mcs = ra_rdata[DW-1:0];
    assign l_vcs = ra_rdata[2*DW-1:DW];
    assign l_mpr = rb_rdata[DW-1:0];
    assign l_vpr = rb_rdata[2*DW-1:DW];
    assign l_cc  = rb_rdata[3*DW-1:2*DW];
    assign l_chc = rb_rdata[4*DW-1:3*DW];

    always_comb
    begin
        dm     = (DW+1)'(l_mcs) - (DW+1)'(l_mpr);
        dv     = (DW+1)'(l_vcs) - (DW+1)'(l_vpr);
        cc_mag = l_cc[DW-1]  ? (~l_cc) + 1'b1  : l_cc;
        ch_mag = l_chc[DW-1] ? (~l_chc) + 1'b1 : l_chc;

        sd1_next        = sd_reg[0];
        sd1_next.zero   = (l_vpr == '0);
        sd1_next.cc_neg = l_cc[DW-1];
        sd1_next.ch_neg = l_chc[DW-1];
        sd1_next.dm_neg = dm[DW];
        sd1_next.dm_mag = dm[DW] ? (~dm) + 1'b1 : dm;
        sd1_next.dv_neg = dv[DW];
        sd1_next.dv_mag = dv[DW] ? (~dv) + 1'b1 : dv;

        // (|cov| << frac) + var/2 for round half away
        dvd_c_next = (DVW'(cc_mag) << FRAC_BITS) + DVW'(l_vpr[VW-1:1]);
        dvd_h_next = (DVW'(ch_mag) << FRAC_BITS) + DVW'(l_vpr[VW-1:1]);
    end

    // ------------------------------------------------------------------
    // gain dividers
    // ------------------------------------------------------------------
    logic [GW-1:0] quot_c;
    logic [GW-1:0] quot_h;

    rtss_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_cell (
        .clk      (clk),
        .adv      (adv),
        .dividend (dvd_c_reg),
        .divisor  (dsr_reg),
        .quot     (quot_c)
    );

    rtss_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_hidden (
        .clk      (clk),
        .adv      (adv),
        .dividend (dvd_h_reg),
        .divisor  (dsr_reg),
        .quot     (quot_h)
    );

    // ------------------------------------------------------------------
    // gain, products, rounding
    // ------------------------------------------------------------------
    logic [GW-1:0] gc_reg;
    logic [GW-1:0] gh_reg;
    logic [63:0]   pcm_reg;
    logic [63:0]   pcc_reg;
    logic [63:0]   phm_reg;
    logic [63:0]   phh_reg;
    logic [TW-1:0] tcm_rnd_reg;
    logic [TW-1:0] thm_rnd_reg;
    logic [GW-1:0] gsc_reg;
    logic [GW-1:0] gsh_reg;
    logic [63:0]   pcv_reg;
    logic [63:0]   phv_reg;
    logic [TW-1:0] tcm_vp_reg;
    logic [TW-1:0] thm_vp_reg;
    logic [TW-1:0] tcm_reg;
    logic [TW-1:0] thm_reg;
    logic [TW-1:0] tcv_reg;
    logic [TW-1:0] thv_reg;

    logic [TW-1:0] gsc_full;
    logic [TW-1:0] gsh_full;
    logic [GW-1:0] gsc_next;
    logic [GW-1:0] gsh_next;

    always_comb
    begin
        // gain squared saturates at the positive limit
        gsc_full = rnd_q(pcc_reg);
        gsh_full = rnd_q(phh_reg);
        gsc_next = (gsc_full[TW-1:GW] != '0) ? '1 : gsc_full[GW-1:0];
        gsh_next = (gsh_full[TW-1:GW] != '0) ? '1 : gsh_full[GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= sd_in;
            sd_reg[1] <= sd1_next;
            for (int s = 2; s < NS; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
            end

            dvd_c_reg <= dvd_c_next;
            dvd_h_reg <= dvd_h_next;
            dsr_reg   <= l_vpr[VW-1:0];

            // zero later prior variance forces a zero gain
            gc_reg <= sd_reg[S_GAIN-1].zero ? '0 : quot_c;
            gh_reg <= sd_reg[S_GAIN-1].zero ? '0 : quot_h;

            pcm_reg <= 64'(gc_reg) * 64'(sd_reg[S_GAIN].dm_mag);
            pcc_reg <= 64'(gc_reg) * 64'(gc_reg);
            phm_reg <= 64'(gh_reg) * 64'(sd_reg[S_GAIN].dm_mag);
            phh_reg <= 64'(gh_reg) * 64'(gh_reg);

            tcm_rnd_reg <= rnd_q(pcm_reg);
            thm_rnd_reg <= rnd_q(phm_reg);
            gsc_reg     <= gsc_next;
            gsh_reg     <= gsh_next;

            pcv_reg    <= 64'(gsc_reg) * 64'(sd_reg[S_RND].dv_mag);
            phv_reg    <= 64'(gsh_reg) * 64'(sd_reg[S_RND].dv_mag);
            tcm_vp_reg <= tcm_rnd_reg;
            thm_vp_reg <= thm_rnd_reg;

            tcv_reg <= rnd_q(pcv_reg);
            thv_reg <= rnd_q(phv_reg);
            tcm_reg <= tcm_vp_reg;
            thm_reg <= thm_vp_reg;
        end
    end

    // ------------------------------------------------------------------
    // final sums and result select
    // ------------------------------------------------------------------
    side_t sd_last;

    assign sd_last = sd_reg[NS-1];

    always_comb
    begin
        res     = '0;
        res.idx = sd_last.idx;
        if (sd_last.oor)
        begin
            res.status = rtss_pkg::ST_RANGE;
        end
        else if (sd_last.fin)
        begin
            res.mcs    = sd_last.mcp;
            res.vcs    = {1'b0, sd_last.vcp};
            res.mhs    = sd_last.mhp;
            res.vhs    = {1'b0, sd_last.vhp};
            res.status = rtss_pkg::ST_OK;
        end
        else
        begin
            res.mcs = add_sat(sd_last.mcp, sd_last.cc_neg ^ sd_last.dm_neg, tcm_reg);
            res.vcs = add_sat({1'b0, sd_last.vcp}, sd_last.dv_neg, tcv_reg);
            res.mhs = add_sat(sd_last.mhp, sd_last.ch_neg ^ sd_last.dm_neg, thm_reg);
            res.vhs = add_sat({1'b0, sd_last.vhp}, sd_last.dv_neg, thv_reg);
            res.status = sd_last.zero ? rtss_pkg::ST_ZERO_VAR : rtss_pkg::ST_OK;
        end
    end

    assign ra_we    = adv && v_reg[NS-1] && !sd_last.oor;
    assign ra_waddr = AW'(sd_last.idx);
    assign ra_wdata = {res.vcs, res.mcs};

    // ------------------------------------------------------------------
    // output register and skid entry
    // ------------------------------------------------------------------
    logic out_v_reg;
    logic skid_v_reg;
    res_t out_reg;
    res_t skid_reg;

    assign adv = !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v_reg <= {v_reg[NS-2:0], acc};
            end
            if (out_v_reg && !m_tready)
            begin
                if (adv && v_reg[NS-1])
                begin
                    skid_v_reg <= 1'b1;
                end
            end
            else if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= v_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && !m_tready)
        begin
            if (adv && v_reg[NS-1])
            begin
                skid_reg <= res;
            end
        end
        else if (skid_v_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, out_reg.vhs, out_reg.mhs, out_reg.vcs, out_reg.mcs, out_reg.idx};
    assign m_tuser  = out_reg.status;

endmodule

// ----- hw/rtl/rtss_ram.sv -----
// ============================================================================
// rtss_ram
// simple dual port ram, one write and one registered read port, read first
// ============================================================================
module rtss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = rtss_pkg::MAX_STATES_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rtss_div_pipe.sv -----
// ============================================================================
// rtss_div_pipe
// pipelined restoring divider for the gain, one quotient bit per stage
// ============================================================================
module rtss_div_pipe #(
    parameter int FRAC_BITS = rtss_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   adv,
    input  logic [rtss_pkg::DATA_W+FRAC_BITS-1:0]  dividend,
    input  logic [rtss_pkg::GAIN_W-1:0]            divisor,
    output logic [rtss_pkg::GAIN_W-1:0]            quot
);

    localparam int DVW = rtss_pkg::DATA_W + FRAC_BITS;
    localparam int QB  = rtss_pkg::GAIN_W;

    logic [QB-1:0] rem_reg  [QB+1];
    logic [QB-1:0] low_reg  [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic [QB-1:0] d_reg    [QB+1];
    logic          sat_reg  [QB+1];

    logic [QB-1:0] rem_next [QB+1];
    logic [QB-1:0] low_next [QB+1];
    logic [QB-1:0] q_next   [QB+1];
    logic          sat0_next;

    always_comb
    begin
        logic [QB:0] t;
        logic        ge;
        // quotient beyond gain range saturates
        sat0_next   = 32'(dividend[DVW-1:QB]) >= 32'(divisor);
        rem_next[0] = sat0_next ? '0 : QB'(dividend[DVW-1:QB]);
        low_next[0] = dividend[QB-1:0];
        q_next[0]   = '0;
        for (int k = 1; k <= QB; k++)
        begin
            t           = {rem_reg[k-1], low_reg[k-1][QB-1]};
            ge          = t >= {1'b0, d_reg[k-1]};
            rem_next[k] = ge ? QB'(t - {1'b0, d_reg[k-1]}) : t[QB-1:0];
            low_next[k] = {low_reg[k-1][QB-2:0], 1'b0};
            q_next[k]   = {q_reg[k-1][QB-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem_next[0];
            low_reg[0] <= low_next[0];
            q_reg[0]   <= q_next[0];
            d_reg[0]   <= divisor;
            sat_reg[0] <= sat0_next;
            for (int k = 1; k <= QB; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                q_reg[k]   <= q_next[k];
                d_reg[k]   <= d_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quot = sat_reg[QB] ? '1 : q_reg[QB];

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench
// self-checking bench for the lstm state rts smoother: a queued stream driver,
// a result monitor and a bit-exact fixed point predictor of the backward pass
// ============================================================================
module testbench;

    localparam int N_RANDOM  = 1900;
    localparam int LIMIT     = 1500000;
    localparam int TAIL      = 120;    // margin to drain the pipeline

    // one input transaction as the bench sees it
    typedef struct packed {
        logic [5:0]  idx;
        logic        fin;
        logic [31:0] mcp;
        logic [30:0] vcp;
        logic [31:0] mhp;
        logic [30:0] vhp;
        logic [31:0] mpr;
        logic [30:0] vpr;
        logic [31:0] cc;
        logic [31:0] chc;
    } elem_t;

    // one predicted result
    typedef struct packed {
        logic [5:0]  st;
        logic [31:0] mcs;
        logic [31:0] vcs;
        logic [31:0] mhs;
        logic [31:0] vhs;
        rtss_pkg::status_t code;
    } smooth_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [263:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [rtss_pkg::CNT_W-1:0] cfg_data;

    lstm_state_rts_smoother_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state: values of the later time step per state index
    int unsigned    state_count;
    longint         nxt_mcs [64];
    longint         nxt_vcs [64];
    longint         nxt_mpr [64];
    longint         nxt_vpr [64];
    longint         nxt_cc  [64];
    longint         nxt_chc [64];
    bit             seeded  [64];   // bench-side: state has a stored step

    elem_t          pending_elems[$];
    smooth_t        expected_smooth[$];
    int             mismatches;
    int             cycle_count;
    bit             stim_done;
    bit             quiet;          // last part of run: no idling
    bit             hold_send;      // sender pauses until drained
    int             s_gap;
    int             m_gap;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round-half-away of (a*b) >> 24, magnitude product in 64 bits
    function automatic longint qmul(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = (ma * mb + 64'd8388608) >> 24;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint qgain(longint cov, longint var_v);
        longint unsigned d;
        longint unsigned q;
        longint unsigned mc;
        if (var_v <= 0)
            return 0;
        d = var_v;
        mc = (cov < 0) ? -cov : cov;
        q = ((mc << 24) + d / 2) / d;
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return (cov < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint qgain_sq(longint g);
        longint s;
        s = qmul(g, g);
        return (s > 64'sd2147483647) ? 64'sd2147483647 : s;
    endfunction

    // backward smoothing step for one element; updates the per-state store
    function automatic smooth_t smooth_elem(elem_t e);
        smooth_t r;
        longint  mcp, mhp, mcs, vcs, mhs, vhs, dm, dv, gc, gh, lvp;
        mcp = longint'($signed(e.mcp));
        mhp = longint'($signed(e.mhp));
        mcs = 0; vcs = 0; mhs = 0; vhs = 0;
        r.code = rtss_pkg::ST_OK;
        if (e.idx >= state_count) begin
            r.code = rtss_pkg::ST_RANGE;
        end else if (e.fin) begin
            mcs = mcp; vcs = e.vcp; mhs = mhp; vhs = e.vhp;
        end else begin
            lvp = nxt_vpr[e.idx];
            dm  = nxt_mcs[e.idx] - nxt_mpr[e.idx];
            dv  = nxt_vcs[e.idx] - lvp;
            gc = 0; gh = 0;
            if (lvp == 0)
                r.code = rtss_pkg::ST_ZERO_VAR;
            else begin
                gc = qgain(nxt_cc[e.idx], lvp);
                gh = qgain(nxt_chc[e.idx], lvp);
            end
            mcs = sat32(mcp + qmul(gc, dm));
            vcs = sat32(longint'(e.vcp) + qmul(qgain_sq(gc), dv));
            mhs = sat32(mhp + qmul(gh, dm));
            vhs = sat32(longint'(e.vhp) + qmul(qgain_sq(gh), dv));
        end
        if (r.code != rtss_pkg::ST_RANGE) begin
            nxt_mcs[e.idx] = mcs;
            nxt_vcs[e.idx] = vcs;
            nxt_mpr[e.idx] = longint'($signed(e.mpr));
            nxt_vpr[e.idx] = e.vpr;
            nxt_cc[e.idx]  = longint'($signed(e.cc));
            nxt_chc[e.idx] = longint'($signed(e.chc));
        end
        r.st  = e.idx;
        r.mcs = mcs[31:0];
        r.vcs = vcs[31:0];
        r.mhs = mhs[31:0];
        r.vhs = vhs[31:0];
        return r;
    endfunction

    // value with a bias toward extremes and small magnitudes
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 2)) - 32'd1;
            3, 4: return 32'($signed($urandom_range(0, 32'h0200_0000))) - 32'h0100_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] pick_var();
        case ($urandom_range(0, 7))
            0: return 31'h7FFF_FFFF;
            1: return 31'd0;
            2: return 31'd1;
            3, 4: return 31'($urandom_range(0, 32'h0200_0000));
            default: return 31'($urandom());
        endcase
    endfunction

    // builds one element; callers build a non-final item only for a seeded state or an out of range index
    function automatic elem_t make_elem(int idx, bit fin);
        elem_t e;
        e.idx = idx[5:0];
        e.fin = fin;
        e.mcp = pick32();
        e.vcp = pick_var();
        e.mhp = pick32();
        e.vhp = pick_var();
        e.mpr = pick32();
        e.vpr = pick_var();
        e.cc  = pick32();
        e.chc = pick32();
        return e;
    endfunction

    // queue an element and note whether it seeds its state
    task automatic push_elem(elem_t e, int cnt);
        pending_elems.push_back(e);
        if (e.idx < cnt)
            seeded[e.idx] = 1'b1;
    endtask

    task automatic wait_drained();
        while (pending_elems.size() != 0 || expected_smooth.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    // register write while the block is idle; stores survive it
    task automatic write_count(int cnt);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cnt[rtss_pkg::CNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        state_count = cnt;
    endtask

    // one time step of sequences, states in descending index order, interleaved
    task automatic push_step(int cnt, bit fin);
        int i;
        for (i = cnt - 1; i >= 0; i--)
            push_elem(make_elem(i, fin | !seeded[i]), cnt);
    endtask

    task automatic run_random(int cnt, int items);
        int   n;
        int   idx;
        elem_t e;
        n = 0;
        while (n < items) begin
            if ($urandom_range(0, 3) != 0) begin
                // well-formed: a whole time step over all states in use
                push_step(cnt, $urandom_range(0, 9) == 0);
                n += cnt;
            end else begin
                // noise: single element, sometimes out of range
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, cnt - 1);
                if (idx < cnt && !seeded[idx])
                    e = make_elem(idx, 1'b1);
                else
                    e = make_elem(idx, $urandom_range(0, 1));
                push_elem(e, cnt);
                n++;
            end
        end
    endtask

    // stimulus
    initial
    begin
        elem_t e;
        int    k;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        stim_done   = 1'b0;
        quiet       = 1'b0;
        hold_send   = 1'b0;
        state_count = rtss_pkg::STATE_COUNT_RST;
        for (k = 0; k < 64; k++)
            seeded[k] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: final step seeds, then extremes, zero prior variance
        e = make_elem(0, 1'b1);
        e.mcp = 32'h7FFF_FFFF; e.vcp = 31'h7FFF_FFFF; e.mhp = 32'h8000_0000;
        e.vhp = '0; e.mpr = 32'h8000_0000; e.vpr = 31'd1;
        e.cc = 32'h7FFF_FFFF; e.chc = 32'h8000_0000;
        push_elem(e, 64);
        e = make_elem(0, 1'b0);    // huge gains, saturated sums
        push_elem(e, 64);
        e = make_elem(1, 1'b1);
        e.vpr = '0;                // later prior variance zero
        push_elem(e, 64);
        e = make_elem(1, 1'b0);    // gains zero, flagged
        push_elem(e, 64);
        e = make_elem(63, 1'b1);
        e.vpr = 31'h7FFF_FFFF; e.cc = 32'h0100_0000; e.chc = 32'hFF00_0000;
        push_elem(e, 64);
        e = make_elem(63, 1'b0);
        e.mcp = '1; e.mhp = '1; e.vcp = '0; e.vhp = 31'h7FFF_FFFF;
        push_elem(e, 64);
        e = make_elem(2, 1'b1);
        e.vpr = 31'h0100_0000; e.cc = 32'h0080_0000; e.chc = 32'hFF80_0001;
        push_elem(e, 64);
        e = make_elem(2, 1'b0);
        push_elem(e, 64);
        write_count(1);            // narrow: most indexes out of range
        push_elem(make_elem(0, 1'b0), 1);
        push_elem(make_elem(1, 1'b0), 1);
        push_elem(make_elem(63, 1'b1), 1);
        push_elem(make_elem(5, 1'b0), 1);

        // random phases over several counts, extremes included
        write_count(64);
        run_random(64, 500);
        write_count(7);
        run_random(7, 350);
        hold_send = 1'b1;          // sender stalls until the block drains
        while (expected_smooth.size() != 0)
            @(posedge clk);
        hold_send = 1'b0;
        write_count(1);
        run_random(1, 200);
        write_count(33);
        run_random(33, 400);
        write_count(64);
        quiet = 1'b1;
        run_random(64, 450);
        while (pending_elems.size() != 0)
            @(posedge clk);
        stim_done = 1'b1;
    end

    // driver: one transaction from the pending queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_gap    <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_smooth.push_back(smooth_elem(pending_elems.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                // hold the current transaction
            end else if (s_gap > 0) begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                s_gap    <= $urandom_range(1, 13);
                s_tvalid <= 1'b0;
            end else if (pending_elems.size() != 0 && !hold_send
                         && !cfg_valid) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, pending_elems[0].chc, pending_elems[0].cc,
                             pending_elems[0].vpr, pending_elems[0].mpr,
                             pending_elems[0].vhp, pending_elems[0].mhp,
                             pending_elems[0].vcp, pending_elems[0].mcp,
                             pending_elems[0].idx};
                s_tuser  <= pending_elems[0].fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: results against the oldest prediction, random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        smooth_t got;
        smooth_t want;
        if (!rst_n) begin
            m_tready    <= 1'b0;
            m_gap       <= 0;
            mismatches  <= 0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (m_tvalid && m_tready) begin
                got.st   = m_tdata[5:0];
                got.mcs  = m_tdata[37:6];
                got.vcs  = m_tdata[69:38];
                got.mhs  = m_tdata[101:70];
                got.vhs  = m_tdata[133:102];
                got.code = rtss_pkg::status_t'(m_tuser);
                if (expected_smooth.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: state %0d status %0d",
                                 got.st, got.code);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_smooth.pop_front();
                    if (got != want) begin
                        if (mismatches < 10)
                            $display({"mismatch: exp st %0d mc %h vc %h mh %h vh %h s %0d",
                                      " / got st %0d mc %h vc %h mh %h vh %h s %0d"},
                                     want.st, want.mcs, want.vcs, want.mhs, want.vhs,
                                     want.code, got.st, got.mcs, got.vcs, got.mhs,
                                     got.vhs, got.code);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap    <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                m_gap    <= $urandom_range(1, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // end of run and watchdog
    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && expected_smooth.size() == 0) && cycle_count < LIMIT)
            @(posedge clk);
        if (cycle_count < LIMIT)
            repeat (TAIL) @(posedge clk);
        if (cycle_count >= LIMIT) begin
            $display("Verification failed");
        end else if (mismatches == 0 && expected_smooth.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
